### src/i2c_register_access_master_top_defines.svh
// Assertion helpers for the I2C register access master.
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_DEFINES_SVH

// Checked only out of reset.
`define I2CRAM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define I2CRAM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/i2cram_pkg.sv
`default_nettype none
package i2cram_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_TICK  = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_READ  = 2'd2;

  localparam logic [2:0] SEG_START = 3'd0;
  localparam logic [2:0] SEG_BYTE  = 3'd1;
  localparam logic [2:0] SEG_ACK   = 3'd2;
  localparam logic [2:0] SEG_RECV  = 3'd3;
  localparam logic [2:0] SEG_NACK  = 3'd4;
  localparam logic [2:0] SEG_STOP  = 3'd5;

  localparam logic [1:0] BYTE_ADDR_W = 2'd0;
  localparam logic [1:0] BYTE_REG    = 2'd1;
  localparam logic [1:0] BYTE_DATA   = 2'd2;
  localparam logic [1:0] BYTE_ADDR_R = 2'd3;

  localparam logic [6:0] WR_LEN       = 7'd88;
  localparam logic [6:0] RD_LEN       = 7'd112;
  localparam logic [6:0] DEV_ADDR_RST = 7'd104;
  localparam logic [7:0] RW_READ_BIT  = 8'h01;

  localparam int         SEG_MAX = 11;
  localparam logic [3:0] WR_SEGS = 4'd8;
  localparam logic [3:0] RD_SEGS = 4'd11;

  localparam logic [2:0] REG_DEV_ADDR = 3'd0;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] arg;
    logic [6:0] start;
  } seg_t;

  typedef struct packed {
    seg_t       seg;
    logic [4:0] off;
  } seg_dec_t;

  function automatic seg_t mk_seg(input logic [2:0] kind, input logic [1:0] arg,
                                  input logic [6:0] start);
    seg_t s;
    s.kind  = kind;
    s.arg   = arg;
    s.start = start;
    return s;
  endfunction

  // Segment table: kind, byte select or ack slot, first phase.
  function automatic seg_t seg_info(input logic rd, input logic [3:0] idx);
    seg_t s;
    s = mk_seg(SEG_STOP, 2'd0, 7'h7F);
    if (rd) begin
      case (idx)
        4'd0:    s = mk_seg(SEG_START, 2'd0,        7'd0);
        4'd1:    s = mk_seg(SEG_BYTE,  BYTE_ADDR_W, 7'd4);
        4'd2:    s = mk_seg(SEG_ACK,   2'd0,        7'd28);
        4'd3:    s = mk_seg(SEG_BYTE,  BYTE_REG,    7'd31);
        4'd4:    s = mk_seg(SEG_ACK,   2'd1,        7'd55);
        4'd5:    s = mk_seg(SEG_START, 2'd0,        7'd58);
        4'd6:    s = mk_seg(SEG_BYTE,  BYTE_ADDR_R, 7'd62);
        4'd7:    s = mk_seg(SEG_ACK,   2'd2,        7'd86);
        4'd8:    s = mk_seg(SEG_RECV,  2'd0,        7'd89);
        4'd9:    s = mk_seg(SEG_NACK,  2'd0,        7'd106);
        4'd10:   s = mk_seg(SEG_STOP,  2'd0,        7'd109);
        default: s = mk_seg(SEG_STOP,  2'd0,        7'h7F);
      endcase
    end else begin
      case (idx)
        4'd0:    s = mk_seg(SEG_START, 2'd0,        7'd0);
        4'd1:    s = mk_seg(SEG_BYTE,  BYTE_ADDR_W, 7'd4);
        4'd2:    s = mk_seg(SEG_ACK,   2'd0,        7'd28);
        4'd3:    s = mk_seg(SEG_BYTE,  BYTE_REG,    7'd31);
        4'd4:    s = mk_seg(SEG_ACK,   2'd1,        7'd55);
        4'd5:    s = mk_seg(SEG_BYTE,  BYTE_DATA,   7'd58);
        4'd6:    s = mk_seg(SEG_ACK,   2'd2,        7'd82);
        4'd7:    s = mk_seg(SEG_STOP,  2'd0,        7'd85);
        default: s = mk_seg(SEG_STOP,  2'd0,        7'h7F);
      endcase
    end
    return s;
  endfunction

  // Find the segment holding phase p: last segment whose start is not above p.
  function automatic seg_dec_t seg_decode(input logic rd, input logic [6:0] p);
    seg_dec_t   d;
    seg_t       s;
    logic [3:0] n;
    logic [6:0] diff;
    n = rd ? RD_SEGS : WR_SEGS;
    d.seg = seg_info(rd, 4'd0);
    for (int i = 0; i < SEG_MAX; i++) begin
      s = seg_info(rd, 4'(i));
      if ((4'(i) < n) && (p >= s.start))
        d.seg = s;
    end
    diff  = p - d.seg.start;
    d.off = diff[4:0];
    return d;
  endfunction

  // Bit position (off / 3) within a 24-phase byte segment.
  function automatic logic [2:0] byte_bit(input logic [4:0] off);
    logic [2:0] b;
    b = 3'd0;
    for (int k = 1; k < 8; k++) begin
      if (off >= 5'(3 * k))
        b = 3'(k);
    end
    return b;
  endfunction

endpackage
`default_nettype wire

### src/i2c_register_access_master_top.sv
// I2C register access master: one request is one bus phase.
// The result is registered: an accepted request passes the input register, then
// the result register. Throughput: one request per cycle while out_stall is low, set by the
// single-pass phase decoder; a write transaction spans 88 requests, a read 112.
// Reset (rst_n low, synchronous): idle, valid flags and sequencer state zero, device address 104.
`default_nettype none
module i2c_register_access_master_top (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire i2cram_pkg::cmd_t in_command,
  input  wire [7:0]             in_reg_addr,
  input  wire [7:0]             in_write_data,
  input  wire                   in_sda_in,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic                  out_scl_level,
  output logic                  out_sda_level,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic [7:0]            out_read_byte,
  output logic [2:0]            out_ack_bits,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire [2:0]             paddr,
  input  wire [31:0]            pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import i2cram_pkg::*;

  // configuration
  logic [6:0] dev_addr_r;

  // input register
  logic       s1_valid_r;
  cmd_t       s1_cmd_r;
  logic [7:0] s1_reg_r;
  logic [7:0] s1_data_r;
  logic       s1_sda_r;

  // sequencer state
  logic [6:0] phase_r, phase_nxt;
  logic       is_read_r, is_read_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] lreg_r, lreg_nxt;
  logic [7:0] ldata_r, ldata_nxt;
  logic [7:0] rxbyte_r, rxbyte_nxt;
  logic [2:0] ack_r, ack_nxt;

  // result register
  logic       out_valid_r;
  logic       scl_r, sda_r, busy_r, done_r;
  logic [7:0] rbyte_r;
  logic [2:0] ackbits_r;

  logic       advance;
  logic       in_fire;
  logic       cfg_wr;

  logic       cmd_start;
  logic       rd_eff;
  logic [6:0] p;
  logic [6:0] seq_len;
  logic       busy;
  logic       done;
  logic       scl_o, sda_o;
  seg_dec_t   dec;
  logic [2:0] bpos;
  logic [4:0] bsub;
  logic [7:0] bval;
  logic [7:0] addr_byte;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_DEV_ADDR);
  assign prdata = (paddr == REG_DEV_ADDR) ? {25'd0, dev_addr_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RST;
    end else if (cfg_wr) begin
      dev_addr_r <= pwdata[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_command;
      s1_reg_r  <= in_reg_addr;
      s1_data_r <= in_write_data;
      s1_sda_r  <= in_sda_in;
    end
  end

  // Phase sequencer
  assign cmd_start = (phase_r == 7'd0) && ((s1_cmd_r == CMD_WRITE) || (s1_cmd_r == CMD_READ));
  assign rd_eff    = cmd_start ? (s1_cmd_r == CMD_READ) : is_read_r;
  assign p         = cmd_start ? 7'd0 : phase_r;
  assign seq_len   = rd_eff ? RD_LEN : WR_LEN;
  assign busy      = cmd_start || ((phase_r != 7'd0) && (phase_r < seq_len));
  assign done      = busy && ((p + 7'd1) >= seq_len);

  assign dec       = seg_decode(rd_eff, p);
  assign bpos      = byte_bit(dec.off);
  assign bsub      = dec.off - ({1'b0, bpos, 1'b0} + {2'b00, bpos});
  assign addr_byte = {dev_addr_r, 1'b0};

  always_comb begin
    case (dec.seg.arg)
      BYTE_ADDR_W: bval = addr_byte;
      BYTE_REG:    bval = lreg_nxt;
      BYTE_DATA:   bval = ldata_nxt;
      default:     bval = addr_byte | RW_READ_BIT;
    endcase
  end

  always_comb begin
    is_read_nxt = is_read_r;
    lreg_nxt    = lreg_r;
    ldata_nxt   = ldata_r;
    ack_nxt     = ack_r;
    shift_nxt   = shift_r;
    rxbyte_nxt  = rxbyte_r;
    phase_nxt   = phase_r;
    scl_o       = 1'b1;
    sda_o       = 1'b1;

    if (cmd_start) begin
      is_read_nxt = (s1_cmd_r == CMD_READ);
      lreg_nxt    = s1_reg_r;
      if (s1_cmd_r == CMD_WRITE)
        ldata_nxt = s1_data_r;
      ack_nxt   = 3'd0;
      shift_nxt = 8'd0;
    end

    if (busy) begin
      case (dec.seg.kind)
        SEG_START: begin
          sda_o = (dec.off < 5'd2);
          scl_o = (dec.off == 5'd0) ? (p == 7'd0) : (dec.off != 5'd3);
        end
        SEG_BYTE: begin
          sda_o = bval[3'd7 - bpos];
          scl_o = (bsub == 5'd1);
        end
        SEG_ACK: begin
          scl_o = (dec.off == 5'd1);
          if ((dec.off == 5'd1) && s1_sda_r)
            ack_nxt = ack_nxt | (3'b001 << dec.seg.arg);
        end
        SEG_RECV: begin
          if (dec.off == 5'd0) begin
            scl_o     = 1'b0;
            shift_nxt = 8'd0;
          end else if (dec.off[0]) begin
            scl_o     = 1'b1;
            shift_nxt = {shift_nxt[6:0], s1_sda_r};
          end else begin
            scl_o = 1'b0;
          end
        end
        SEG_NACK: begin
          scl_o = (dec.off == 5'd1);
        end
        SEG_STOP: begin
          sda_o = (dec.off == 5'd2);
          scl_o = (dec.off != 5'd0);
        end
        default: begin
          scl_o = 1'b1;
          sda_o = 1'b1;
        end
      endcase

      if (done) begin
        phase_nxt = 7'd0;
        if (rd_eff)
          rxbyte_nxt = shift_nxt;
      end else begin
        phase_nxt = p + 7'd1;
      end
    end else begin
      phase_nxt = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 7'd0;
      is_read_r <= 1'b0;
      shift_r   <= 8'd0;
      lreg_r    <= 8'd0;
      ldata_r   <= 8'd0;
      rxbyte_r  <= 8'd0;
      ack_r     <= 3'd0;
    end else if (s1_valid_r && advance) begin
      phase_r   <= phase_nxt;
      is_read_r <= is_read_nxt;
      shift_r   <= shift_nxt;
      lreg_r    <= lreg_nxt;
      ldata_r   <= ldata_nxt;
      rxbyte_r  <= rxbyte_nxt;
      ack_r     <= ack_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance) begin
      scl_r     <= scl_o;
      sda_r     <= sda_o;
      busy_r    <= busy;
      done_r    <= done;
      rbyte_r   <= rxbyte_nxt;
      ackbits_r <= ack_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = scl_r;
  assign out_sda_level = sda_r;
  assign out_busy_res  = busy_r;
  assign out_done_res  = done_r;
  assign out_read_byte = rbyte_r;
  assign out_ack_bits  = ackbits_r;

`include "i2c_register_access_master_top_defines.svh"

  `I2CRAM_ASSERT(a_done_busy, (out_valid_r && done_r) |-> busy_r, "done without busy")
  `I2CRAM_ASSERT(a_idle_released, (out_valid_r && !busy_r) |-> (scl_r && sda_r),
                 "bus driven while idle")
  `I2CRAM_ASSERT_ALWAYS(a_phase_range,
                        !rst_n || (phase_r == 7'd0) ||
                        (phase_r < (is_read_r ? RD_LEN : WR_LEN)),
                        "phase beyond sequence end")
  `I2CRAM_ASSERT(a_stall_needs_item, in_stall |-> s1_valid_r, "stall with empty input stage")

endmodule
`default_nettype wire
